// ----- rtl/core/bswp_pkg.sv -----
// Package for the boot script word parser: magic and command codes,
// parse phase encoding, result codes and the beat structures.
// No dependencies.
package bswp_pkg;

  localparam logic [31:0] MagicWord    = 32'h4150_4954;
  localparam logic [31:0] CmdLoad      = 32'h5853_5901;
  localparam logic [31:0] CmdFill      = 32'h5853_590A;
  localparam logic [31:0] CmdJumpClose = 32'h5853_5906;
  localparam logic [31:0] CmdJump      = 32'h5853_5905;

  localparam int unsigned WordW     = 32;
  localparam int unsigned FillW     = 30;
  localparam int unsigned KindW     = 2;
  localparam int unsigned OutDataW  = 128;

  typedef enum logic [8:0] {
    PH_MAGIC     = 9'b0_0000_0001,
    PH_CMD       = 9'b0_0000_0010,
    PH_LOAD_ADDR = 9'b0_0000_0100,
    PH_LOAD_SIZE = 9'b0_0000_1000,
    PH_LOAD_DATA = 9'b0_0001_0000,
    PH_FILL_ADDR = 9'b0_0010_0000,
    PH_FILL_SIZE = 9'b0_0100_0000,
    PH_JUMP_ADDR = 9'b0_1000_0000,
    PH_HALT      = 9'b1_0000_0000
  } phase_e;

  typedef enum logic [KindW-1:0] {
    RES_WRITE     = 2'd0,
    RES_FILL      = 2'd1,
    RES_ENTRY     = 2'd2,
    RES_BAD_MAGIC = 2'd3
  } res_kind_e;

  typedef enum logic {
    IN_WORD      = 1'b0,
    IN_NEW_IMAGE = 1'b1
  } in_kind_e;

  typedef struct packed {
    in_kind_e         kind;
    logic [WordW-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    res_kind_e        kind;
    logic [WordW-1:0] address;
    logic [WordW-1:0] data;
    logic [FillW-1:0] fill_words;
    logic [WordW-1:0] byte_offset;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

endpackage

// ----- rtl/core/bswp_in_reg.sv -----
// Input register stage of the boot script word parser.
// Depends on bswp_pkg.
module bswp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bswp_pkg::in_item_t item_i,
  input  logic              advance_i,
  output bswp_pkg::stage_t  stage_o
);

  logic               valid_q, valid_d;
  bswp_pkg::in_item_t item_q;
  logic               load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ----- rtl/core/bswp_decode.sv -----
// Parse state and per-word decode of the boot script word parser.
// Holds phase, destination address, load byte count and consumed byte count.
// Depends on bswp_pkg.
module bswp_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  bswp_pkg::in_item_t  item_i,
  output bswp_pkg::res_beat_t beat_o,
  output bswp_pkg::phase_e    phase_o
);

  bswp_pkg::phase_e phase_q, phase_d;
  logic [31:0]      dest_q, dest_d;
  logic [31:0]      left_q, left_d;
  logic [31:0]      used_q, used_d;
  logic [31:0]      used_inc;
  logic             size_pos;
  logic [31:0]      size_rnd;

  assign used_inc = used_q + 32'd4;
  assign size_pos = (item_i.word != 32'd0) && !item_i.word[31];
  assign size_rnd = item_i.word + 32'd3;

  always_comb begin
    phase_d = phase_q;
    dest_d  = dest_q;
    left_d  = left_q;
    used_d  = used_q;
    beat_o  = '0;
    if (item_i.kind == bswp_pkg::IN_NEW_IMAGE) begin
      phase_d = bswp_pkg::PH_MAGIC;
      dest_d  = '0;
      left_d  = '0;
      used_d  = '0;
    end else if (phase_q != bswp_pkg::PH_HALT) begin
      used_d = used_inc;
      case (phase_q)
        bswp_pkg::PH_MAGIC: begin
          if (item_i.word != bswp_pkg::MagicWord) begin
            phase_d            = bswp_pkg::PH_HALT;
            beat_o.valid       = 1'b1;
            beat_o.res.kind    = bswp_pkg::RES_BAD_MAGIC;
          end else begin
            phase_d = bswp_pkg::PH_CMD;
          end
        end
        bswp_pkg::PH_CMD: begin
          if (item_i.word == bswp_pkg::CmdLoad) begin
            phase_d = bswp_pkg::PH_LOAD_ADDR;
          end else if (item_i.word == bswp_pkg::CmdFill) begin
            phase_d = bswp_pkg::PH_FILL_ADDR;
          end else if (item_i.word == bswp_pkg::CmdJumpClose ||
                       item_i.word == bswp_pkg::CmdJump) begin
            phase_d = bswp_pkg::PH_JUMP_ADDR;
          end
        end
        bswp_pkg::PH_LOAD_ADDR: begin
          dest_d  = item_i.word;
          phase_d = bswp_pkg::PH_LOAD_SIZE;
        end
        bswp_pkg::PH_LOAD_SIZE: begin
          if (size_pos) begin
            left_d  = item_i.word;
            phase_d = bswp_pkg::PH_LOAD_DATA;
          end else begin
            phase_d = bswp_pkg::PH_CMD;
          end
        end
        bswp_pkg::PH_LOAD_DATA: begin
          beat_o.valid       = 1'b1;
          beat_o.res.kind    = bswp_pkg::RES_WRITE;
          beat_o.res.address = dest_q;
          beat_o.res.data    = item_i.word;
          dest_d             = dest_q + 32'd4;
          if (left_q <= 32'd4) begin
            left_d  = '0;
            phase_d = bswp_pkg::PH_CMD;
          end else begin
            left_d = left_q - 32'd4;
          end
        end
        bswp_pkg::PH_FILL_ADDR: begin
          dest_d  = item_i.word;
          phase_d = bswp_pkg::PH_FILL_SIZE;
        end
        bswp_pkg::PH_FILL_SIZE: begin
          phase_d            = bswp_pkg::PH_CMD;
          beat_o.valid       = 1'b1;
          beat_o.res.kind    = bswp_pkg::RES_FILL;
          beat_o.res.address = dest_q;
          beat_o.res.fill_words = size_pos ? size_rnd[31:2] : '0;
        end
        bswp_pkg::PH_JUMP_ADDR: begin
          phase_d                = bswp_pkg::PH_HALT;
          beat_o.valid           = 1'b1;
          beat_o.res.kind        = bswp_pkg::RES_ENTRY;
          beat_o.res.address     = item_i.word;
          beat_o.res.byte_offset = used_inc;
        end
        default: begin
          phase_d = bswp_pkg::PH_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bswp_pkg::PH_MAGIC;
      dest_q  <= '0;
      left_q  <= '0;
      used_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      dest_q  <= dest_d;
      left_q  <= left_d;
      used_q  <= used_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// ----- rtl/core/bswp_out_reg.sv -----
// Result register stage of the boot script word parser.
// Depends on bswp_pkg.
module bswp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  bswp_pkg::res_beat_t beat_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output bswp_pkg::result_t   res_o
);

  logic              valid_q, valid_d;
  bswp_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = beat_i.valid;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && beat_i.valid) begin
      res_q <= beat_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/core/boot_script_word_parser_unit.sv -----
// Top level of the boot script word parser: input register, decode, result register.
// Depends on bswp_pkg, bswp_in_reg, bswp_decode, bswp_out_reg.
//
// Usage:
//  Slave channel carries one image word per beat; tuser = 1 restarts parsing
//  of a new image (word ignored, no result). The first image word must be the
//  magic word, else one bad-magic result is given and the parser halts.
//  Master channel carries at most one result per input beat: word writes for
//  section loads, one fill record per section fill, the entry address with
//  the bytes consumed for a jump (parser then halts until a new image).
//  Path: an input beat passes the input register and the decode, and its
//  result is then held in the result register for the master side.
//  Throughput: one beat per cycle while results are taken; the decode is combinational.
//  Reset: parser expects the magic word, counters clear, both stages empty.
//  Stall: a held result blocks decode; the input register still takes one
//  beat, then tready drops until the result beat is taken.
module boot_script_word_parser_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // word
  input  logic                           s_axis_tuser_i,  // kind
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // address[31:0], data[63:32], fill_words[93:64], byte_offset[125:94], zero pad
  output logic [bswp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic [bswp_pkg::KindW-1:0]     m_axis_tuser_o   // result_kind
);

  bswp_pkg::in_item_t  in_item;
  bswp_pkg::stage_t    stage;
  bswp_pkg::res_beat_t beat;
  bswp_pkg::result_t   res;
  bswp_pkg::phase_e    phase;
  logic                out_free;
  logic                advance;

  assign in_item.kind = bswp_pkg::in_kind_e'(s_axis_tuser_i);
  assign in_item.word = s_axis_tdata_i;
  assign advance      = stage.valid && out_free;

  bswp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .stage_o   (stage)
  );

  bswp_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage.item),
    .beat_o    (beat),
    .phase_o   (phase)
  );

  bswp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (beat),
    .free_o    (out_free),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {2'b00, res.byte_offset, res.fill_words, res.data, res.address};
  assign m_axis_tuser_o = res.kind;

`ifndef SYNTHESIS
  a_new_image_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage.item.kind == bswp_pkg::IN_NEW_IMAGE |=> phase == bswp_pkg::PH_MAGIC)
    else $error("new image beat did not return parser to magic phase");

  a_entry_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && beat.valid && beat.res.kind == bswp_pkg::RES_ENTRY
    |=> phase == bswp_pkg::PH_HALT)
    else $error("entry result without halt");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase == bswp_pkg::PH_HALT |-> !beat.valid)
    else $error("result produced while halted");

  a_fill_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.kind != bswp_pkg::RES_FILL |-> res.fill_words == '0)
    else $error("fill count on non-fill result");
`endif

endmodule
